>>> rtl/vpof_pkg.sv
// Shared widths, register map, reset values and the exponent root table.
`timescale 1ns / 1ps
`default_nettype none

package vpof_pkg;

  // Field widths
  localparam int PITCH_W = 20;
  localparam int BASE_W  = 26;
  localparam int FREQ_W  = 34;

  // Pitch and table resolution
  localparam int FRACTION_BITS  = 16;
  localparam int TABLE_BITS     = 10;
  localparam int EFF_TABLE_BITS = (TABLE_BITS < FRACTION_BITS) ? TABLE_BITS : FRACTION_BITS;
  localparam int WEIGHT_BITS    = FRACTION_BITS - EFF_TABLE_BITS;
  localparam int WGT_W          = (WEIGHT_BITS > 0) ? WEIGHT_BITS : 1;

  // 2^x table: Q1.30 entries, 2^T + 1 of them
  localparam int ROM_W      = 32;
  localparam int ROM_FRAC   = 30;
  localparam int ROM_DEPTH  = (2 ** EFF_TABLE_BITS) + 1;
  localparam int ROM_ADDR_W = EFF_TABLE_BITS + 1;

  localparam logic [ROM_W-1:0] ACC_ONE    = ROM_W'(64'd1 << ROM_FRAC);
  localparam logic [ROM_W-1:0] ACC_TWO    = ROM_W'(64'd2 << ROM_FRAC);
  localparam logic [63:0]      ROUND_HALF = 64'd1 << (ROM_FRAC - 1);

  // Product and octave shift
  localparam int P_W     = BASE_W + ROM_W;
  localparam int SHIFT_W = ((PITCH_W > FRACTION_BITS) ? (PITCH_W - FRACTION_BITS) : 1) + 7;
  localparam logic [FREQ_W-1:0] FREQ_MAX = '1;

  // Configuration port
  localparam int APB_ADDR_W = 4;
  localparam int APB_DATA_W = 32;
  localparam int REG_IDX_W  = 2;
  localparam logic [REG_IDX_W-1:0] REG_BASE_FREQ = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_PITCH_LOW = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_PITCH_HIGH = 2'd2;

  localparam logic [BASE_W-1:0]         BASE_RST = BASE_W'(17145889);
  localparam logic signed [PITCH_W-1:0] LOW_RST  = PITCH_W'(-327680);
  localparam logic signed [PITCH_W-1:0] HIGH_RST = PITCH_W'(393216);

  typedef enum logic [1:0] {
    ST_FILL = 2'b01,
    ST_RUN  = 2'b10
  } fill_state_e;

  typedef logic [ROM_W-1:0] root_tab_t [EFF_TABLE_BITS+1];

  function automatic logic [63:0] isqrt64(input logic [63:0] x);
    logic [63:0] rem;
    logic [63:0] res;
    logic [63:0] bit_v;
    rem = x;
    res = '0;
    for (int i = 31; i >= 0; i--) begin
      bit_v = 64'd1 << (2 * i);
      if (rem >= res + bit_v) begin
        rem = rem - (res + bit_v);
        res = (res >> 1) + bit_v;
      end else begin
        res = res >> 1;
      end
    end
    return res;
  endfunction

  // Successive square roots of two, Q1.30: r0 = 2, rj = sqrt(r(j-1))
  function automatic root_tab_t calc_roots();
    root_tab_t r;
    r[0] = ACC_TWO;
    for (int j = 1; j <= EFF_TABLE_BITS; j++) begin
      r[j] = ROM_W'(isqrt64({32'd0, r[j-1]} << ROM_FRAC));
    end
    return r;
  endfunction

  localparam root_tab_t ROOTS = calc_roots();

endpackage

`default_nettype wire

>>> rtl/vpof_rom.sv
// 2^x table memory with its post-reset fill sequencer and two read ports.
`timescale 1ns / 1ps
`default_nettype none

module vpof_rom (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                rd_en_i,
  input  wire logic [vpof_pkg::EFF_TABLE_BITS-1:0] rd_idx_i,
  output logic      [vpof_pkg::ROM_W-1:0]          rd_lo_o,
  output logic      [vpof_pkg::ROM_W-1:0]          rd_hi_o,
  output logic                                     ready_o
);

  localparam int T = vpof_pkg::EFF_TABLE_BITS;

  logic [vpof_pkg::ROM_W-1:0] rom_mem [vpof_pkg::ROM_DEPTH];

  vpof_pkg::fill_state_e            state_q, state_d;
  logic [vpof_pkg::ROM_ADDR_W-1:0]  cnt_q, cnt_d;

  // Partial products: lvl_q[i] holds the entry after all index bits above i
  logic [vpof_pkg::ROM_W-1:0] lvl_q [T+1];

  logic                       run_c;
  logic [T-1:0]               upd_c;
  logic [vpof_pkg::ROM_W-1:0] pre_c;
  logic [vpof_pkg::ROM_W-1:0] root_c;
  logic [63:0]                prod_c;
  logic [vpof_pkg::ROM_W-1:0] step_c;
  logic [vpof_pkg::ROM_W-1:0] wr_data_c;
  logic                       filling;
  logic                       first_c;
  logic                       last_c;

  logic [vpof_pkg::ROM_W-1:0] rd_lo_q, rd_hi_q;

  assign filling = (state_q == vpof_pkg::ST_FILL);
  assign first_c = (cnt_q == '0);
  assign last_c  = (cnt_q == vpof_pkg::ROM_ADDR_W'(vpof_pkg::ROM_DEPTH - 1));

  // Next entry differs from the shared prefix by one root at its lowest set bit
  always_comb begin
    run_c  = 1'b1;
    upd_c  = '0;
    pre_c  = '0;
    root_c = '0;
    for (int i = 0; i < T; i++) begin
      upd_c[i] = run_c;
      if (run_c && cnt_q[i]) begin
        pre_c  = lvl_q[i+1];
        root_c = vpof_pkg::ROOTS[T-i];
        run_c  = 1'b0;
      end
    end
    prod_c = {32'd0, pre_c} * {32'd0, root_c};
    step_c = vpof_pkg::ROM_W'((prod_c + vpof_pkg::ROUND_HALF) >> vpof_pkg::ROM_FRAC);
    if (first_c) begin
      wr_data_c = vpof_pkg::ACC_ONE;
    end else if (last_c) begin
      wr_data_c = vpof_pkg::ACC_TWO;
    end else begin
      wr_data_c = step_c;
    end
  end

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    unique case (state_q)
      vpof_pkg::ST_FILL: begin
        cnt_d = cnt_q + 1'b1;
        if (last_c) begin
          state_d = vpof_pkg::ST_RUN;
        end
      end
      vpof_pkg::ST_RUN: begin
        cnt_d = cnt_q;
      end
      default: begin
        state_d = vpof_pkg::ST_FILL;
        cnt_d   = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= vpof_pkg::ST_FILL;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (filling) begin
      if (first_c) begin
        for (int i = 0; i <= T; i++) begin
          lvl_q[i] <= vpof_pkg::ACC_ONE;
        end
      end else if (!last_c) begin
        for (int i = 0; i < T; i++) begin
          if (upd_c[i]) begin
            lvl_q[i] <= step_c;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (filling) begin
      rom_mem[cnt_q] <= wr_data_c;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_lo_q <= rom_mem[{1'b0, rd_idx_i}];
      rd_hi_q <= rom_mem[vpof_pkg::ROM_ADDR_W'(rd_idx_i) + 1'b1];
    end
  end

  assign rd_lo_o = rd_lo_q;
  assign rd_hi_o = rd_hi_q;
  assign ready_o = (state_q == vpof_pkg::ST_RUN);

endmodule

`default_nettype wire

>>> rtl/volt_per_octave_to_frequency.sv
// Top level: one-volt-per-octave pitch to frequency converter with APB registers.
`timescale 1ns / 1ps
`default_nettype none

// Converts a Q4.16 pitch voltage to base_frequency * 2^pitch in unsigned Q18.16 Hz.
// The pitch is first limited to [pitch_low, pitch_high] (low limit checked first) and
// clamped_o flags an item that was limited. The integer volts become an octave shift;
// the fraction picks two neighbouring entries of a 1025-entry 2^x table (Q1.30) and
// interpolates linearly between them. Results above 2^34 - 1 saturate.
// Throughput is one item per clock unless the output stalls; an accepted item passes
// the stages table read, interpolation, base multiply and octave shift to out_valid_o.
// The table lives in an on-chip memory read at two addresses per cycle; after reset a
// fill pass writes it one entry per cycle, during which in_stall_o stays high. Register
// writes are taken at any time, fill included. Registers: base_frequency at 0x0,
// pitch_low at 0x4, pitch_high at 0x8; pitch limits read back sign-extended.

module volt_per_octave_to_frequency (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,

  input  wire logic                                 psel,
  input  wire logic                                 penable,
  input  wire logic                                 pwrite,
  input  wire logic [vpof_pkg::APB_ADDR_W-1:0]      paddr,
  input  wire logic [vpof_pkg::APB_DATA_W-1:0]      pwdata,
  output logic      [vpof_pkg::APB_DATA_W-1:0]      prdata,
  output logic                                      pready,

  input  wire logic                                 in_valid_i,
  output logic                                      in_stall_o,
  input  wire logic signed [vpof_pkg::PITCH_W-1:0]  pitch_volts_i,

  output logic                                      out_valid_o,
  input  wire logic                                 out_stall_i,
  output logic      [vpof_pkg::FREQ_W-1:0]          frequency_o,
  output logic                                      clamped_o
);

  localparam int SW = vpof_pkg::SHIFT_W;

  // ---------------------------------------------------------------- registers
  logic [vpof_pkg::BASE_W-1:0]         base_q;
  logic signed [vpof_pkg::PITCH_W-1:0] low_q;
  logic signed [vpof_pkg::PITCH_W-1:0] high_q;
  logic                                cfg_we;
  logic [vpof_pkg::REG_IDX_W-1:0]      cfg_idx;

  assign pready  = 1'b1;
  assign cfg_we  = psel && penable && pwrite && pready;
  assign cfg_idx = paddr[vpof_pkg::APB_ADDR_W-1:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q <= vpof_pkg::BASE_RST;
      low_q  <= vpof_pkg::LOW_RST;
      high_q <= vpof_pkg::HIGH_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        vpof_pkg::REG_BASE_FREQ:  base_q <= pwdata[vpof_pkg::BASE_W-1:0];
        vpof_pkg::REG_PITCH_LOW:  low_q  <= pwdata[vpof_pkg::PITCH_W-1:0];
        vpof_pkg::REG_PITCH_HIGH: high_q <= pwdata[vpof_pkg::PITCH_W-1:0];
        default: begin
          // drop writes to unmapped addresses
        end
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      vpof_pkg::REG_BASE_FREQ:  prdata = vpof_pkg::APB_DATA_W'(base_q);
      vpof_pkg::REG_PITCH_LOW:  prdata = vpof_pkg::APB_DATA_W'(low_q);
      vpof_pkg::REG_PITCH_HIGH: prdata = vpof_pkg::APB_DATA_W'(high_q);
      default:                  prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------- flow control
  // The whole pipe moves as one; it holds only when a finished item waits at the output.
  logic adv;
  logic rom_ready;
  logic accept;

  assign adv        = !(out_valid_o && out_stall_i);
  assign in_stall_o = !(adv && rom_ready);
  assign accept     = in_valid_i && !in_stall_o;

  // ---------------------------------------------------------------- stage 0: limit, split
  logic signed [vpof_pkg::PITCH_W-1:0]  v0;
  logic                                 cl0;
  logic signed [31:0]                   vx0;
  logic [vpof_pkg::FRACTION_BITS-1:0]   f0;
  logic [vpof_pkg::EFF_TABLE_BITS-1:0]  idx0;
  logic [vpof_pkg::WGT_W-1:0]           w0;
  logic signed [SW-1:0]                 n0;
  logic signed [SW-1:0]                 s0;

  always_comb begin
    // Low limit wins when the limits are crossed
    if (pitch_volts_i < low_q) begin
      v0  = low_q;
      cl0 = 1'b1;
    end else if (pitch_volts_i > high_q) begin
      v0  = high_q;
      cl0 = 1'b1;
    end else begin
      v0  = pitch_volts_i;
      cl0 = 1'b0;
    end
    vx0  = 32'(v0);
    f0   = vx0[vpof_pkg::FRACTION_BITS-1:0];
    idx0 = vpof_pkg::EFF_TABLE_BITS'(f0 >> vpof_pkg::WEIGHT_BITS);
    w0   = (vpof_pkg::WEIGHT_BITS == 0) ? '0 : f0[vpof_pkg::WGT_W-1:0];
    n0   = SW'(vx0 >>> vpof_pkg::FRACTION_BITS);
    // Right-shift amount that takes the Q.46 product to Q.16, less the octave count
    s0   = SW'(vpof_pkg::ROM_FRAC) - n0;
  end

  logic [vpof_pkg::ROM_W-1:0] rd_lo, rd_hi;

  vpof_rom u_rom (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .rd_en_i  (adv),
    .rd_idx_i (idx0),
    .rd_lo_o  (rd_lo),
    .rd_hi_o  (rd_hi),
    .ready_o  (rom_ready)
  );

  logic                       v1_q, v2_q, v3_q, out_valid_q;
  logic [vpof_pkg::WGT_W-1:0] w1_q;
  logic signed [SW-1:0]       s1_q, s2_q, s3_q;
  logic                       cl1_q, cl2_q, cl3_q, cl_out_q;
  logic [vpof_pkg::ROM_W-1:0] m2_q;
  logic [vpof_pkg::P_W-1:0]   p3_q;
  logic [vpof_pkg::FREQ_W-1:0] freq_q;

  // ---------------------------------------------------------------- stage 1: interpolate
  logic [vpof_pkg::ROM_W-1:0]             diff1;
  logic [vpof_pkg::ROM_W+vpof_pkg::WGT_W-1:0] dw1;
  logic [vpof_pkg::ROM_W-1:0]             m1;

  always_comb begin
    diff1 = rd_hi - rd_lo;
    dw1   = (vpof_pkg::ROM_W + vpof_pkg::WGT_W)'(diff1) *
            (vpof_pkg::ROM_W + vpof_pkg::WGT_W)'(w1_q);
    m1    = rd_lo + vpof_pkg::ROM_W'(dw1 >> vpof_pkg::WEIGHT_BITS);
  end

  // ---------------------------------------------------------------- stage 2: base multiply
  logic [vpof_pkg::P_W-1:0] p2;

  assign p2 = vpof_pkg::P_W'(base_q) * vpof_pkg::P_W'(m2_q);

  // ---------------------------------------------------------------- stage 3: octave shift
  logic [SW-1:0]               l3;
  logic [vpof_pkg::P_W-1:0]    rsh3, lsh3, hi3;
  logic [vpof_pkg::FREQ_W-1:0] freq3;

  always_comb begin
    l3   = SW'(-s3_q);
    rsh3 = p3_q >> unsigned'(s3_q);
    lsh3 = p3_q << l3;
    hi3  = p3_q >> (SW'(vpof_pkg::FREQ_W) - l3);
    if (s3_q > 0) begin
      if (|rsh3[vpof_pkg::P_W-1:vpof_pkg::FREQ_W]) begin
        freq3 = vpof_pkg::FREQ_MAX;
      end else begin
        freq3 = rsh3[vpof_pkg::FREQ_W-1:0];
      end
    end else if (p3_q == '0) begin
      freq3 = '0;
    end else if ((l3 >= SW'(vpof_pkg::FREQ_W)) || (hi3 != '0)) begin
      freq3 = vpof_pkg::FREQ_MAX;
    end else begin
      freq3 = lsh3[vpof_pkg::FREQ_W-1:0];
    end
  end

  // ---------------------------------------------------------------- pipeline registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      v3_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      v1_q        <= accept;
      v2_q        <= v1_q;
      v3_q        <= v2_q;
      out_valid_q <= v3_q;
    end
  end

  // Advance payload with the valids; hold everything while the output stalls
  always_ff @(posedge clk_i) begin
    if (adv) begin
      w1_q     <= w0;
      s1_q     <= s0;
      cl1_q    <= cl0;
      m2_q     <= m1;
      s2_q     <= s1_q;
      cl2_q    <= cl1_q;
      p3_q     <= p2;
      s3_q     <= s2_q;
      cl3_q    <= cl2_q;
      freq_q   <= freq3;
      cl_out_q <= cl3_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign frequency_o = freq_q;
  assign clamped_o   = cl_out_q;

endmodule

`default_nettype wire

>>> sim/testbench.sv
// Self-checking testbench for the volt-per-octave pitch to frequency converter.
`timescale 1ns / 1ps

// Pitch items go in over a valid/stall channel. Frequency items come back over a
// second valid/stall channel. Each accepted pitch item is converted by a local
// model of the block: limit to [pitch_low, pitch_high], split into octave and
// fraction, look up a 2^x table with linear interpolation, multiply by the base
// frequency and shift by the octave. The expected item is queued, and every
// returned item is compared against the oldest entry in that queue.
//
// The run has two parts:
//   - a directed script: known values at reset, range extremes, the clamp edges,
//     crossed limits, and the largest and zero base frequency;
//   - eight random phases, each with fresh register values and one of four mixes of
//     sender gaps and receiver stalls.
// Registers are only rewritten once the queue has drained and the pipeline
// has had time to settle.

module testbench;
  import vpof_pkg::*;

  // Model resolution, matching the block's build.
  localparam int FRAC_BITS   = 16;
  localparam int TAB_BITS    = 10;
  localparam int WGT_BITS    = FRAC_BITS - TAB_BITS;
  localparam int DUT_LATENCY = 4;
  localparam int PHASE_ITEMS = 155;
  localparam logic [FREQ_W-1:0] FREQ_CEIL = '1;

  typedef struct packed {
    logic [FREQ_W-1:0] freq;
    logic              clamped;
  } conv_t;

  // Directed script rows: a pitch checked against the model, a pitch with its
  // result typed in, or a register write.
  typedef enum logic [1:0] {
    ROW_PITCH,
    ROW_TYPED,
    ROW_WRITE
  } row_kind_e;

  typedef struct packed {
    row_kind_e              kind;
    logic [REG_IDX_W-1:0]   sel;
    logic [31:0]            value;
    logic [FREQ_W-1:0]      freq;
    logic                   clamped;
  } script_row_t;

  localparam int SCRIPT_LEN = 28;

  script_row_t script [SCRIPT_LEN] = '{
    // Reset limits (-5 V .. +6 V) and reset base frequency (middle C).
    '{ROW_TYPED, REG_BASE_FREQ,  32'(0),        34'd17145889,   1'b0},
    '{ROW_TYPED, REG_BASE_FREQ,  32'(65536),    34'd34291778,   1'b0},
    '{ROW_TYPED, REG_BASE_FREQ,  32'(-65536),   34'd8572944,    1'b0},
    '{ROW_TYPED, REG_BASE_FREQ,  32'(-327680),  34'd535809,     1'b0},
    '{ROW_TYPED, REG_BASE_FREQ,  32'(393216),   34'd1097336896, 1'b0},
    '{ROW_TYPED, REG_BASE_FREQ,  32'(-524288),  34'd535809,     1'b1},
    '{ROW_TYPED, REG_BASE_FREQ,  32'(524287),   34'd1097336896, 1'b1},
    '{ROW_TYPED, REG_BASE_FREQ,  32'(-327681),  34'd535809,     1'b1},
    '{ROW_TYPED, REG_BASE_FREQ,  32'(393217),   34'd1097336896, 1'b1},
    // Fractions: half step, smallest, largest, all ones, alternating bits.
    '{ROW_PITCH, REG_BASE_FREQ,  32'(32768),    34'd0,          1'b0},
    '{ROW_PITCH, REG_BASE_FREQ,  32'(1),        34'd0,          1'b0},
    '{ROW_PITCH, REG_BASE_FREQ,  32'(65535),    34'd0,          1'b0},
    '{ROW_PITCH, REG_BASE_FREQ,  32'(-1),       34'd0,          1'b0},
    '{ROW_PITCH, REG_BASE_FREQ,  32'h0005_5555, 34'd0,          1'b0},
    '{ROW_PITCH, REG_BASE_FREQ,  32'h000A_AAAA, 34'd0,          1'b0},
    // Largest base and full pitch range: the top of the output range.
    '{ROW_WRITE, REG_BASE_FREQ,  32'h03FF_FFFF, 34'd0,          1'b0},
    '{ROW_WRITE, REG_PITCH_LOW,  32'(-524288),  34'd0,          1'b0},
    '{ROW_WRITE, REG_PITCH_HIGH, 32'(524287),   34'd0,          1'b0},
    '{ROW_PITCH, REG_BASE_FREQ,  32'(524287),   34'd0,          1'b0},
    '{ROW_PITCH, REG_BASE_FREQ,  32'(-524288),  34'd0,          1'b0},
    // Zero base frequency.
    '{ROW_WRITE, REG_BASE_FREQ,  32'(0),        34'd0,          1'b0},
    '{ROW_TYPED, REG_BASE_FREQ,  32'(123456),   34'd0,          1'b0},
    // Crossed limits: low = +1 V, high = -1 V; the low test wins.
    '{ROW_WRITE, REG_BASE_FREQ,  32'(17145889), 34'd0,          1'b0},
    '{ROW_WRITE, REG_PITCH_LOW,  32'(65536),    34'd0,          1'b0},
    '{ROW_WRITE, REG_PITCH_HIGH, 32'(-65536),   34'd0,          1'b0},
    '{ROW_TYPED, REG_BASE_FREQ,  32'(0),        34'd34291778,   1'b1},
    '{ROW_TYPED, REG_BASE_FREQ,  32'(131072),   34'd8572944,    1'b1},
    '{ROW_TYPED, REG_BASE_FREQ,  32'(-131072),  34'd34291778,   1'b1}
  };

  // Clock, reset and DUT-facing signals, all known from time zero.
  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic                  apb_sel     = 1'b0;
  logic                  apb_enable  = 1'b0;
  logic                  apb_write   = 1'b0;
  logic [APB_ADDR_W-1:0] apb_addr    = '0;
  logic [APB_DATA_W-1:0] apb_wdata   = '0;
  logic [APB_DATA_W-1:0] apb_rdata;
  logic                  apb_ready;

  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [PITCH_W-1:0]    pitch    = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [FREQ_W-1:0]     frequency;
  logic                  clamped;

  // Shadow copies of the registers, at reset values.
  logic [BASE_W-1:0]         base_hz  = 26'd17145889;
  logic signed [PITCH_W-1:0] low_lim  = -20'sd327680;
  logic signed [PITCH_W-1:0] high_lim = 20'sd393216;

  // Q1.30 table of 2^(k / 2^TAB_BITS), one extra entry for exactly 2.0.
  logic [31:0] exp_table [0:(1 << TAB_BITS)];

  // Expected items in acceptance order.
  conv_t freq_due [$];
  conv_t head;

  // Typed result that travels with the current pitch item, if any.
  logic  typed_known  = 1'b0;
  conv_t typed_result = '0;

  int gap_pct     = 0;
  int stall_pct   = 0;
  int bad_results = 0;

  always #1 clk = ~clk;

  volt_per_octave_to_frequency dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .psel          (apb_sel),
    .penable       (apb_enable),
    .pwrite        (apb_write),
    .paddr         (apb_addr),
    .pwdata        (apb_wdata),
    .prdata        (apb_rdata),
    .pready        (apb_ready),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall),
    .pitch_volts_i (pitch),
    .out_valid_o   (out_valid),
    .out_stall_i   (out_stall),
    .frequency_o   (frequency),
    .clamped_o     (clamped)
  );

  // Build the table: roots r0 = 2, rj = sqrt(r(j-1)), then a product of the
  // roots picked by the bits of each index, rounded half up at each step.
  initial begin : build_exp_table
    logic [63:0] roots [TAB_BITS+1];
    logic [63:0] acc;
    logic [63:0] trial;
    roots[0] = 64'd2 << 30;
    for (int j = 1; j <= TAB_BITS; j++) begin
      // Greedy bitwise floor square root of r(j-1) * 2^30.
      roots[j] = 64'd0;
      for (int b = 31; b >= 0; b--) begin
        trial = roots[j] | (64'd1 << b);
        if (trial * trial <= (roots[j-1] << 30)) roots[j] = trial;
      end
    end
    for (int k = 0; k < (1 << TAB_BITS); k++) begin
      acc = 64'd1 << 30;
      for (int j = 1; j <= TAB_BITS; j++) begin
        if (((k >> (TAB_BITS - j)) & 1) != 0) acc = (acc * roots[j] + (64'd1 << 29)) >> 30;
      end
      exp_table[k] = acc[31:0];
    end
    exp_table[1 << TAB_BITS] = 32'h8000_0000;
  end

  // Convert one pitch with the current shadow registers.
  function automatic conv_t pitch_to_freq(input logic [PITCH_W-1:0] raw);
    conv_t r;
    logic signed [PITCH_W-1:0] v;
    int octave;
    int idx;
    int wgt;
    int shift;
    logic [63:0] mant;
    logic [63:0] prod;
    logic [63:0] q;
    v = raw;
    r.clamped = 1'b0;
    // Low limit first, so crossed limits resolve to pitch_low for low inputs.
    if (v < low_lim) begin
      v = low_lim;
      r.clamped = 1'b1;
    end else if (v > high_lim) begin
      v = high_lim;
      r.clamped = 1'b1;
    end
    octave = int'(v >>> FRAC_BITS);
    idx    = int'(v[FRAC_BITS-1:0]) >> WGT_BITS;
    wgt    = int'(v[FRAC_BITS-1:0]) & ((1 << WGT_BITS) - 1);
    // Interpolate between neighbours, truncating.
    mant = 64'(exp_table[idx])
         + ((64'(exp_table[idx+1] - exp_table[idx]) * 64'(wgt)) >> WGT_BITS);
    prod = 64'(base_hz) * mant;
    // Q11.46 product to Q18.16, scaled by 2^octave; saturate on the way up.
    shift = 30 - octave;
    if (shift >= 64) q = 64'd0;
    else if (shift >= 0) q = prod >> shift;
    else if (prod == 64'd0) q = 64'd0;
    else if (-shift >= FREQ_W || prod > (64'(FREQ_CEIL) >> -shift)) q = 64'(FREQ_CEIL);
    else q = prod << -shift;
    r.freq = (q > 64'(FREQ_CEIL)) ? FREQ_CEIL : q[FREQ_W-1:0];
    return r;
  endfunction

  // Queue the expectation for every accepted pitch item.
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall)
      freq_due.insert(freq_due.size(), typed_known ? typed_result : pitch_to_freq(pitch));
  end

  // Random receiver back-pressure at the phase's rate.
  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < stall_pct);
  end

  // Compare every accepted frequency item with the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (freq_due.size() == 0) begin
        bad_results++;
        if (bad_results <= 10)
          $display("unexpected item: frequency %0d clamped %0d", frequency, clamped);
      end else begin
        head = freq_due.pop_front();
        if (frequency !== head.freq || clamped !== head.clamped) begin
          bad_results++;
          if (bad_results <= 10)
            $display("mismatch: expected frequency %0d clamped %0d, got %0d clamped %0d",
                     head.freq, head.clamped, frequency, clamped);
        end
      end
    end
  end

  // Offer one pitch item after a random gap; hold it until it is taken.
  task automatic send_pitch(input logic [PITCH_W-1:0] pv, input logic known,
                            input logic [FREQ_W-1:0] want_freq, input logic want_clamped);
    while ($urandom_range(0, 99) < gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    pitch        <= pv;
    typed_known  <= known;
    typed_result <= {want_freq, want_clamped};
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Drop valid and wait until every expected item has come back.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (freq_due.size() != 0) @(posedge clk);
    repeat (DUT_LATENCY + 4) @(posedge clk);
  endtask

  // Setup cycle, access cycle, then the bus goes idle before the next transfer.
  task automatic write_reg(input logic [REG_IDX_W-1:0] sel, input logic [31:0] data);
    apb_sel    <= 1'b1;
    apb_enable <= 1'b0;
    apb_write  <= 1'b1;
    apb_addr   <= {sel, 2'b00};
    apb_wdata  <= data;
    @(posedge clk);
    apb_enable <= 1'b1;
    @(posedge clk);
    while (!apb_ready) @(posedge clk);
    apb_sel    <= 1'b0;
    apb_enable <= 1'b0;
    apb_write  <= 1'b0;
    case (sel)
      REG_BASE_FREQ:  base_hz  = data[BASE_W-1:0];
      REG_PITCH_LOW:  low_lim  = data[PITCH_W-1:0];
      REG_PITCH_HIGH: high_lim = data[PITCH_W-1:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  initial begin
    script_row_t row;
    logic [PITCH_W-1:0]        pv;
    logic [BASE_W-1:0]         nb;
    logic signed [PITCH_W-1:0] lo;
    logic signed [PITCH_W-1:0] hi;
    logic signed [PITCH_W-1:0] a;
    logic signed [PITCH_W-1:0] b;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Directed script; the table fill after reset shows up as a long stall.
    for (int i = 0; i < SCRIPT_LEN; i++) begin
      row = script[i];
      if (row.kind == ROW_WRITE) begin
        settle();
        write_reg(row.sel, row.value);
      end else begin
        send_pitch(row.value[PITCH_W-1:0], row.kind == ROW_TYPED, row.freq, row.clamped);
      end
    end

    // Random phases: new registers, new idle mix.
    for (int ph = 0; ph < 8; ph++) begin
      settle();
      case (ph % 4)
        0:       begin gap_pct = 0;  stall_pct = 0;  end
        1:       begin gap_pct = 51; stall_pct = 0;  end
        2:       begin gap_pct = 0;  stall_pct = 51; end
        default: begin gap_pct = 26; stall_pct = 26; end
      endcase
      case (ph)
        0: begin
          nb = 26'd17145889;
          lo = -20'sd327680;
          hi = 20'sd393216;
        end
        1: begin
          nb = '1;
          lo = {1'b1, {(PITCH_W-1){1'b0}}};
          hi = {1'b0, {(PITCH_W-1){1'b1}}};
        end
        2: begin
          nb = 26'd1;
          lo = -20'sd131072;
          hi = 20'sd65536;
        end
        3: begin
          // Crossed limits.
          nb = BASE_W'($urandom);
          lo = PITCH_W'($urandom_range(0, 262144));
          hi = -PITCH_W'($urandom_range(1, 262144));
        end
        4: begin
          // Equal limits: every pitch lands on one value.
          nb = BASE_W'($urandom);
          a  = PITCH_W'($urandom);
          lo = a;
          hi = a;
        end
        default: begin
          nb = BASE_W'($urandom);
          a  = PITCH_W'($urandom);
          b  = PITCH_W'($urandom);
          lo = (a > b) ? b : a;
          hi = (a > b) ? a : b;
        end
      endcase
      write_reg(REG_BASE_FREQ, 32'(nb));
      write_reg(REG_PITCH_LOW, 32'(lo));
      write_reg(REG_PITCH_HIGH, 32'(hi));

      for (int i = 0; i < PHASE_ITEMS; i++) begin
        // Halfway through, hold off until the pipeline is empty.
        if (i == PHASE_ITEMS / 2) settle();
        case ($urandom_range(0, 9))
          0:       pv = low_lim + PITCH_W'($urandom_range(0, 4)) - PITCH_W'(2);
          1:       pv = high_lim + PITCH_W'($urandom_range(0, 4)) - PITCH_W'(2);
          2:       pv = PITCH_W'($urandom_range(0, 15)) << FRAC_BITS;
          default: pv = PITCH_W'($urandom);
        endcase
        send_pitch(pv, 1'b0, '0, 1'b0);
      end
    end

    settle();
    if (bad_results == 0 && freq_due.size() == 0) begin
      $display("** volt_per_octave_to_frequency: PASSED **");
    end else begin
      $display("** volt_per_octave_to_frequency: FAILED **");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #1000000;
    $display("** volt_per_octave_to_frequency: FAILED **");
    $finish;
  end

endmodule
